// ===== rtl/sv39ptb_pkg.sv =====
// ----------------------------------------------------------------------------
// sv39ptb_pkg
// shared types and constants of the sv39 page table builder
// ----------------------------------------------------------------------------
package sv39ptb_pkg;

  localparam int DEF_POOL_PAGES = 16;
  localparam int ENTRY_BITS     = 9;
  localparam int PPN_W          = 44;
  localparam int VPN_W          = 27;
  localparam int PTE_W          = 64;
  localparam int PERM_W         = 8;
  localparam int COUNT_W        = 7;
  localparam int TSEL_W         = 4;
  localparam int STATUS_W       = 2;
  localparam int ADDED_W        = 2;
  localparam int MAX_RUN        = 64;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [PTE_W-1:0] PTE_V = 64'h01;
  localparam logic [PTE_W-1:0] PTE_A = 64'h40;
  localparam logic [PTE_W-1:0] PTE_D = 64'h80;

  localparam logic OP_MAP  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 2'd2;

  typedef struct packed {
    logic                  is_read;
    logic [VPN_W-1:0]      vpn;
    logic [PPN_W-1:0]      ppn;
    logic [COUNT_W-1:0]    count;
    logic [PERM_W-1:0]     perm;
    logic [TSEL_W-1:0]     tsel;
    logic [ENTRY_BITS-1:0] esel;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PTE_W-1:0]    entry;
    logic [VPN_W-1:0]    vpn;
    logic [TSEL_W-1:0]   leaf_table;
    logic [ADDED_W-1:0]  added;
    logic                last;
  } res_t;

endpackage

// ===== rtl/sv39_page_table_builder_core.sv =====
// ----------------------------------------------------------------------------
// sv39_page_table_builder_core
// builds sv39 three-level page tables in an internal pool of table pages
// ----------------------------------------------------------------------------
// channel  | direction | handshake              | payload
// in_      | input     | in_valid / in_ready    | opcode, pages, count, flags, selects
// out_     | output    | out_valid / out_ready  | status, entry, page, table, added, last
// cfg_     | input     | cfg_valid / cfg_ready  | pool base ppn
//
// after reset a clearing pass over all POOL_PAGES * 512 entries zeroes the table memory;
// requests wait in the queue until it ends, configuration writes are taken at once
// a read passes the entry read, data and emit states; a mapped page passes the root
// read and check, the level-1 read and check, the leaf write and emit, and each new
// table page adds a zeroing sweep of its 512 entries and a pointer write (the level-1
// read is skipped for a new root entry)
// a stalled result blocks the walker only; the front keeps filling a 2-entry queue
// ----------------------------------------------------------------------------
module sv39_page_table_builder_core #(
  parameter int POOL_PAGES = sv39ptb_pkg::DEF_POOL_PAGES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [sv39ptb_pkg::VPN_W-1:0]       in_virtual_page,
  input  logic [sv39ptb_pkg::PPN_W-1:0]       in_physical_page,
  input  logic [sv39ptb_pkg::COUNT_W-1:0]     in_page_count,
  input  logic [sv39ptb_pkg::PERM_W-1:0]      in_permission,
  input  logic [sv39ptb_pkg::TSEL_W-1:0]      in_table_select,
  input  logic [sv39ptb_pkg::ENTRY_BITS-1:0]  in_entry_select,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sv39ptb_pkg::STATUS_W-1:0]    out_status,
  output logic [sv39ptb_pkg::PTE_W-1:0]       out_entry_value,
  output logic [sv39ptb_pkg::VPN_W-1:0]       out_mapped_page,
  output logic [sv39ptb_pkg::TSEL_W-1:0]      out_leaf_table,
  output logic [sv39ptb_pkg::ADDED_W-1:0]     out_tables_added,
  output logic                                out_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sv39ptb_pkg::PPN_W-1:0]       cfg_data
);

  logic [sv39ptb_pkg::PPN_W-1:0] pool_base_r, pool_base_nxt;
  logic              q_full, q_push, q_pop, q_not_empty;
  sv39ptb_pkg::cmd_t push_cmd, pop_cmd;
  sv39ptb_pkg::res_t res;

  assign cfg_ready     = 1'b1;
  assign pool_base_nxt = (cfg_valid && cfg_ready) ? cfg_data : pool_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= '0;
    end else begin
      pool_base_r <= pool_base_nxt;
    end
  end

  sv39ptb_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_virtual_page  (in_virtual_page),
    .in_physical_page (in_physical_page),
    .in_page_count    (in_page_count),
    .in_permission    (in_permission),
    .in_table_select  (in_table_select),
    .in_entry_select  (in_entry_select),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (push_cmd)
  );

  sv39ptb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (pop_cmd)
  );

  sv39ptb_back #(
    .POOL_PAGES (POOL_PAGES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pool_base (pool_base_r),
    .q_valid   (q_not_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_status       = res.status;
  assign out_entry_value  = res.entry;
  assign out_mapped_page  = res.vpn;
  assign out_leaf_table   = res.leaf_table;
  assign out_tables_added = res.added;
  assign out_last         = res.last;

endmodule

// ===== rtl/sv39ptb_front.sv =====
// ----------------------------------------------------------------------------
// sv39ptb_front
// takes requests, sorts map from read, clamps the run length, drops empty runs
// ----------------------------------------------------------------------------
module sv39ptb_front (
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [sv39ptb_pkg::VPN_W-1:0]       in_virtual_page,
  input  logic [sv39ptb_pkg::PPN_W-1:0]       in_physical_page,
  input  logic [sv39ptb_pkg::COUNT_W-1:0]     in_page_count,
  input  logic [sv39ptb_pkg::PERM_W-1:0]      in_permission,
  input  logic [sv39ptb_pkg::TSEL_W-1:0]      in_table_select,
  input  logic [sv39ptb_pkg::ENTRY_BITS-1:0]  in_entry_select,
  input  logic                                q_full,
  output logic                                q_push,
  output sv39ptb_pkg::cmd_t                   q_cmd
);

  logic is_read;
  logic [sv39ptb_pkg::COUNT_W-1:0] count_sat;

  assign is_read   = (in_opcode == sv39ptb_pkg::OP_READ);
  assign count_sat = (in_page_count > sv39ptb_pkg::COUNT_W'(sv39ptb_pkg::MAX_RUN)) ?
                     sv39ptb_pkg::COUNT_W'(sv39ptb_pkg::MAX_RUN) : in_page_count;

  assign in_ready = !q_full;
  // an empty map run yields nothing, so it is taken and dropped here
  assign q_push   = in_valid && !q_full && (is_read || (count_sat != '0));

  always_comb begin
    q_cmd         = '0;
    q_cmd.is_read = is_read;
    q_cmd.vpn     = in_virtual_page;
    q_cmd.ppn     = in_physical_page;
    q_cmd.count   = count_sat;
    q_cmd.perm    = in_permission;
    q_cmd.tsel    = in_table_select;
    q_cmd.esel    = in_entry_select;
  end

endmodule

// ===== rtl/sv39ptb_queue.sv =====
// ----------------------------------------------------------------------------
// sv39ptb_queue
// short command queue between the front and the table walker
// ----------------------------------------------------------------------------
module sv39ptb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sv39ptb_pkg::cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output sv39ptb_pkg::cmd_t pop_cmd
);

  localparam int QD  = sv39ptb_pkg::QUEUE_DEPTH;
  localparam int QPW = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCW = $clog2(QD + 1);

  sv39ptb_pkg::cmd_t slot_r [QD];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full      = (cnt_r == QCW'(QD));
  assign not_empty = (cnt_r != '0);
  assign pop_cmd   = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/sv39ptb_back.sv =====
// ----------------------------------------------------------------------------
// sv39ptb_back
// table walker: owns the table memory, walks, allocates and writes entries
// ----------------------------------------------------------------------------
module sv39ptb_back #(
  parameter int POOL_PAGES = sv39ptb_pkg::DEF_POOL_PAGES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [sv39ptb_pkg::PPN_W-1:0]  pool_base,
  input  logic                           q_valid,
  input  sv39ptb_pkg::cmd_t              q_cmd,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sv39ptb_pkg::res_t              out_res
);

  localparam int EB        = sv39ptb_pkg::ENTRY_BITS;
  localparam int PW        = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int NW        = $clog2(POOL_PAGES + 1);
  localparam int AW        = PW + EB;
  localparam int DEPTH     = POOL_PAGES * (1 << EB);
  localparam int PPN_W     = sv39ptb_pkg::PPN_W;
  localparam int PTE_W     = sv39ptb_pkg::PTE_W;
  localparam int TSEL_W    = sv39ptb_pkg::TSEL_W;

  typedef enum logic [11:0] {
    S_CLEAR    = 12'b000000000001,
    S_IDLE     = 12'b000000000010,
    S_RD_ENT   = 12'b000000000100,
    S_RD_DATA  = 12'b000000001000,
    S_ROOT_RD  = 12'b000000010000,
    S_ROOT_CHK = 12'b000000100000,
    S_MID_RD   = 12'b000001000000,
    S_MID_CHK  = 12'b000010000000,
    S_ZERO     = 12'b000100000000,
    S_PTR_WR   = 12'b001000000000,
    S_LEAF_WR  = 12'b010000000000,
    S_EMIT     = 12'b100000000000
  } state_t;

  logic [PTE_W-1:0] mem [DEPTH];
  logic [PTE_W-1:0] rdata_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [PTE_W-1:0] mem_wdata;

  state_t state_r, state_nxt;
  sv39ptb_pkg::cmd_t cmd_r, cmd_nxt;
  logic [sv39ptb_pkg::VPN_W-1:0]   vpn_r, vpn_nxt;
  logic [PPN_W-1:0]                ppn_r, ppn_nxt;
  logic [sv39ptb_pkg::COUNT_W-1:0] left_r, left_nxt;
  logic [NW-1:0]                   nf_r, nf_nxt;
  logic [PW-1:0]                   l1_r, l1_nxt, l0_r, l0_nxt;
  logic [1:0]                      need_r, need_nxt, pend_r, pend_nxt;
  logic [AW-1:0]                   swp_r, swp_nxt;
  sv39ptb_pkg::res_t               res_r, res_nxt, out_r;
  logic                            out_valid_r, out_valid_nxt, out_load;

  logic [EB-1:0]    v2, v1, v0;
  logic [PW-1:0]    nf_idx, tsel_idx;
  logic [PW+3:0]    tsel_ext, l0_ext;
  logic             t_outside;
  logic [PPN_W-1:0] dec_d;
  logic             dec_ok;
  logic [1:0]       chk_need;
  logic             chk_bad, exhaust;
  logic [PTE_W-1:0] ptr_val, leaf_val;

  assign v2       = vpn_r[3*EB-1:2*EB];
  assign v1       = vpn_r[2*EB-1:EB];
  assign v0       = vpn_r[EB-1:0];
  assign nf_idx   = nf_r[PW-1:0];
  assign tsel_ext = (PW+4)'(cmd_r.tsel);
  assign tsel_idx = tsel_ext[PW-1:0];
  assign l0_ext   = (PW+4)'(l0_r);
  assign t_outside = (tsel_ext >= (PW+4)'(POOL_PAGES));

  // pointer decode shared by both walk levels
  assign dec_d  = rdata_r[PPN_W+9:10] - pool_base;
  assign dec_ok = (dec_d < PPN_W'(POOL_PAGES));

  always_comb begin
    if (!rdata_r[0]) begin
      chk_need = (state_r == S_ROOT_CHK) ? 2'd2 : 2'd1;
      chk_bad  = 1'b0;
    end else begin
      chk_need = 2'd0;
      chk_bad  = !dec_ok;
    end
  end

  assign exhaust  = ((NW+1)'(nf_r) + (NW+1)'(chk_need)) > (NW+1)'(POOL_PAGES);
  assign ptr_val  = {10'b0, pool_base + PPN_W'(nf_idx), 10'b0} | sv39ptb_pkg::PTE_V;
  assign leaf_val = {10'b0, ppn_r, 10'b0} | PTE_W'(cmd_r.perm) | sv39ptb_pkg::PTE_V |
                    sv39ptb_pkg::PTE_A | sv39ptb_pkg::PTE_D;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    vpn_nxt   = vpn_r;
    ppn_nxt   = ppn_r;
    left_nxt  = left_r;
    nf_nxt    = nf_r;
    l1_nxt    = l1_r;
    l0_nxt    = l0_r;
    need_nxt  = need_r;
    pend_nxt  = pend_r;
    swp_nxt   = swp_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = swp_r;
        swp_nxt   = swp_r + 1'b1;
        if (swp_r == AW'(DEPTH - 1)) begin
          swp_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          vpn_nxt   = q_cmd.vpn;
          ppn_nxt   = q_cmd.ppn;
          left_nxt  = q_cmd.count;
          state_nxt = q_cmd.is_read ? S_RD_ENT : S_ROOT_RD;
        end
      end
      S_RD_ENT: begin
        mem_raddr = {tsel_idx, cmd_r.esel};
        state_nxt = S_RD_DATA;
      end
      S_RD_DATA: begin
        res_nxt.status     = t_outside ? sv39ptb_pkg::ST_OUTSIDE : sv39ptb_pkg::ST_OK;
        res_nxt.entry      = t_outside ? '0 : rdata_r;
        res_nxt.vpn        = '0;
        res_nxt.leaf_table = cmd_r.tsel;
        res_nxt.added      = '0;
        res_nxt.last       = 1'b1;
        state_nxt          = S_EMIT;
      end
      S_ROOT_RD: begin
        mem_raddr = {PW'(0), v2};
        state_nxt = S_ROOT_CHK;
      end
      S_MID_RD: begin
        mem_raddr = {l1_r, v1};
        state_nxt = S_MID_CHK;
      end
      S_ROOT_CHK, S_MID_CHK: begin
        res_nxt.entry      = '0;
        res_nxt.vpn        = vpn_r;
        res_nxt.leaf_table = '0;
        res_nxt.added      = '0;
        res_nxt.last       = 1'b1;
        if (chk_bad) begin
          res_nxt.status = sv39ptb_pkg::ST_OUTSIDE;
          state_nxt      = S_EMIT;
        end else if (rdata_r[0]) begin
          if (state_r == S_ROOT_CHK) begin
            l1_nxt    = dec_d[PW-1:0];
            state_nxt = S_MID_RD;
          end else begin
            l0_nxt    = dec_d[PW-1:0];
            need_nxt  = 2'd0;
            state_nxt = S_LEAF_WR;
          end
        end else if (exhaust) begin
          res_nxt.status = sv39ptb_pkg::ST_EXHAUSTED;
          state_nxt      = S_EMIT;
        end else begin
          need_nxt  = chk_need;
          pend_nxt  = chk_need;
          swp_nxt   = '0;
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        mem_we    = 1'b1;
        mem_waddr = {nf_idx, swp_r[EB-1:0]};
        swp_nxt   = swp_r + 1'b1;
        if (swp_r[EB-1:0] == '1) begin
          swp_nxt   = '0;
          state_nxt = S_PTR_WR;
        end
      end
      S_PTR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = ptr_val;
        nf_nxt    = nf_r + 1'b1;
        pend_nxt  = pend_r - 1'b1;
        if (pend_r == 2'd2) begin
          mem_waddr = {PW'(0), v2};
          l1_nxt    = nf_idx;
          state_nxt = S_ZERO;
        end else begin
          mem_waddr = {l1_r, v1};
          l0_nxt    = nf_idx;
          state_nxt = S_LEAF_WR;
        end
      end
      S_LEAF_WR: begin
        mem_we             = 1'b1;
        mem_waddr          = {l0_r, v0};
        mem_wdata          = leaf_val;
        res_nxt.status     = sv39ptb_pkg::ST_OK;
        res_nxt.entry      = leaf_val;
        res_nxt.vpn        = vpn_r;
        res_nxt.leaf_table = l0_ext[TSEL_W-1:0];
        res_nxt.added      = need_r;
        res_nxt.last       = (left_r == sv39ptb_pkg::COUNT_W'(1));
        state_nxt          = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if (res_r.last) begin
            state_nxt = S_IDLE;
          end else begin
            vpn_nxt   = vpn_r + 1'b1;
            ppn_nxt   = ppn_r + 1'b1;
            left_nxt  = left_r - 1'b1;
            state_nxt = S_ROOT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      swp_r       <= '0;
      nf_r        <= NW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      swp_r       <= swp_nxt;
      nf_r        <= nf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    vpn_r  <= vpn_nxt;
    ppn_r  <= ppn_nxt;
    left_r <= left_nxt;
    l1_r   <= l1_nxt;
    l0_r   <= l0_nxt;
    need_r <= need_nxt;
    pend_r <= pend_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  // table memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  a_nf_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nf_r >= NW'(1)) && (nf_r <= NW'(POOL_PAGES)))
    else $error("free page pointer out of range");

  a_zero_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ZERO) |-> (nf_r < NW'(POOL_PAGES)))
    else $error("zeroing a page beyond the pool");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!out_valid_r && !q_pop))
    else $error("activity during the clearing pass");

  a_leaf_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LEAF_WR) |-> ((NW+1)'(l0_r) < (NW+1)'(POOL_PAGES)))
    else $error("leaf table index outside the pool");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives map and read requests into the sv39 page table builder under several
// pool base settings and idling mixes, and checks every result against a
// predicted copy of the table pool
// ----------------------------------------------------------------------------

class sv39_table_scoreboard;
  localparam int POOL = sv39ptb_pkg::DEF_POOL_PAGES;
  logic [sv39ptb_pkg::PTE_W-1:0] pool_mem [0:POOL*512-1];
  int unsigned                   free_page;
  logic [sv39ptb_pkg::PPN_W-1:0] base_ppn;
  sv39ptb_pkg::res_t             expected_q [$];
  int unsigned                   mismatches;

  function new();
    foreach (pool_mem[k]) pool_mem[k] = '0;
    free_page  = 1;
    base_ppn   = '0;
    mismatches = 0;
  endfunction

  function void set_base(logic [sv39ptb_pkg::PPN_W-1:0] b);
    base_ppn = b;
  endfunction

  // pool index of a pointer entry, -1 when it falls outside the pool
  function int pool_index(logic [sv39ptb_pkg::PTE_W-1:0] e);
    logic [sv39ptb_pkg::PPN_W-1:0] d;
    d = e[sv39ptb_pkg::PPN_W+9:10] - base_ppn;
    return (d < POOL) ? int'(d) : -1;
  endfunction

  function logic [sv39ptb_pkg::PTE_W-1:0] pointer_entry(int idx);
    logic [sv39ptb_pkg::PPN_W-1:0] p;
    p = base_ppn + sv39ptb_pkg::PPN_W'(idx);
    return {10'd0, p, 10'd0} | sv39ptb_pkg::PTE_V;
  endfunction

  function int grab_page();
    int p;
    p = free_page;
    for (int k = 0; k < 512; k++) pool_mem[p*512+k] = '0;
    free_page++;
    return p;
  endfunction

  function void note_request(sv39ptb_pkg::cmd_t c);
    sv39ptb_pkg::res_t r;
    int unsigned n;
    logic [sv39ptb_pkg::VPN_W-1:0] va;
    logic [sv39ptb_pkg::PPN_W-1:0] pa;
    logic [sv39ptb_pkg::PTE_W-1:0] leaf;
    int l1, l0, need;
    logic [sv39ptb_pkg::STATUS_W-1:0] st;
    if (c.is_read == sv39ptb_pkg::OP_READ) begin
      r = '{status: sv39ptb_pkg::ST_OK,
            entry: pool_mem[int'(c.tsel)*512 + int'(c.esel)], vpn: '0,
            leaf_table: c.tsel, added: '0, last: 1'b1};
      if (c.tsel >= POOL) begin
        r.status = sv39ptb_pkg::ST_OUTSIDE;
        r.entry  = '0;
      end
      expected_q.push_back(r);
      return;
    end
    n = (c.count > sv39ptb_pkg::MAX_RUN) ? sv39ptb_pkg::MAX_RUN : c.count;
    for (int unsigned i = 0; i < n; i++) begin
      va = c.vpn + sv39ptb_pkg::VPN_W'(i);
      pa = c.ppn + sv39ptb_pkg::PPN_W'(i);
      l1 = 0; l0 = 0; need = 0; st = sv39ptb_pkg::ST_OK;
      if (!pool_mem[va[26:18]][0]) begin
        need = 2;
      end else begin
        l1 = pool_index(pool_mem[va[26:18]]);
        if (l1 < 0) st = sv39ptb_pkg::ST_OUTSIDE;
        else if (!pool_mem[l1*512 + va[17:9]][0]) need = 1;
        else begin
          l0 = pool_index(pool_mem[l1*512 + va[17:9]]);
          if (l0 < 0) st = sv39ptb_pkg::ST_OUTSIDE;
        end
      end
      if (st == sv39ptb_pkg::ST_OK && need > POOL - free_page)
        st = sv39ptb_pkg::ST_EXHAUSTED;
      if (st != sv39ptb_pkg::ST_OK) begin
        expected_q.push_back('{status: st, entry: '0, vpn: va, leaf_table: '0,
                               added: '0, last: 1'b1});
        return;
      end
      if (need == 2) begin
        l1 = grab_page();
        pool_mem[va[26:18]] = pointer_entry(l1);
      end
      if (need >= 1) begin
        l0 = grab_page();
        pool_mem[l1*512 + va[17:9]] = pointer_entry(l0);
      end
      leaf = {10'd0, pa, 10'd0} | sv39ptb_pkg::PTE_W'(c.perm) | sv39ptb_pkg::PTE_V |
             sv39ptb_pkg::PTE_A | sv39ptb_pkg::PTE_D;
      pool_mem[l0*512 + va[8:0]] = leaf;
      expected_q.push_back('{status: sv39ptb_pkg::ST_OK, entry: leaf, vpn: va,
                             leaf_table: sv39ptb_pkg::TSEL_W'(l0),
                             added: sv39ptb_pkg::ADDED_W'(need),
                             last: (i + 1 == n)});
    end
  endfunction

  function void check_result(sv39ptb_pkg::res_t got);
    sv39ptb_pkg::res_t w;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %p", $time, got);
      mismatches++;
      return;
    end
    w = expected_q.pop_front();
    if (got.status !== w.status) begin
      $display("%0t: status expected %0d actual %0d", $time, w.status, got.status);
      mismatches++;
    end
    if (got.entry !== w.entry) begin
      $display("%0t: entry expected %h actual %h", $time, w.entry, got.entry);
      mismatches++;
    end
    if (got.vpn !== w.vpn) begin
      $display("%0t: mapped page expected %h actual %h", $time, w.vpn, got.vpn);
      mismatches++;
    end
    if (got.leaf_table !== w.leaf_table) begin
      $display("%0t: leaf table expected %0d actual %0d", $time, w.leaf_table,
               got.leaf_table);
      mismatches++;
    end
    if (got.added !== w.added) begin
      $display("%0t: tables added expected %0d actual %0d", $time, w.added, got.added);
      mismatches++;
    end
    if (got.last !== w.last) begin
      $display("%0t: last expected %0d actual %0d", $time, w.last, got.last);
      mismatches++;
    end
  endfunction
endclass

module tb_top;
  localparam int QUIET_LIMIT = 40000;

  logic clk, rst_n;
  logic in_valid, in_ready, in_opcode;
  logic [sv39ptb_pkg::VPN_W-1:0] in_virtual_page;
  logic [sv39ptb_pkg::PPN_W-1:0] in_physical_page;
  logic [sv39ptb_pkg::COUNT_W-1:0] in_page_count;
  logic [sv39ptb_pkg::PERM_W-1:0] in_permission;
  logic [sv39ptb_pkg::TSEL_W-1:0] in_table_select;
  logic [sv39ptb_pkg::ENTRY_BITS-1:0] in_entry_select;
  logic out_valid, out_ready;
  logic [sv39ptb_pkg::STATUS_W-1:0] out_status;
  logic [sv39ptb_pkg::PTE_W-1:0] out_entry_value;
  logic [sv39ptb_pkg::VPN_W-1:0] out_mapped_page;
  logic [sv39ptb_pkg::TSEL_W-1:0] out_leaf_table;
  logic [sv39ptb_pkg::ADDED_W-1:0] out_tables_added;
  logic out_last;
  logic cfg_valid, cfg_ready;
  logic [sv39ptb_pkg::PPN_W-1:0] cfg_data;

  sv39_table_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  sv39_page_table_builder_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_opcode = sv39ptb_pkg::OP_MAP; in_virtual_page = '0;
    in_physical_page = '0; in_page_count = '0; in_permission = '0;
    in_table_select = '0; in_entry_select = '0; out_ready = 1'b0;
    cfg_valid = 1'b0; cfg_data = '0;
  end

  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{status: out_status, entry: out_entry_value,
                        vpn: out_mapped_page, leaf_table: out_leaf_table,
                        added: out_tables_added, last: out_last});
  end

  // watchdog: quiet stretch covers the clearing pass and table zeroing
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_request(sv39ptb_pkg::cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= c.is_read;
    in_virtual_page  <= c.vpn;
    in_physical_page <= c.ppn;
    in_page_count    <= c.count;
    in_permission    <= c.perm;
    in_table_select  <= c.tsel;
    in_entry_select  <= c.esel;
    do @(posedge clk); while (!in_ready);
    sb.note_request(c);
  endtask

  task automatic map_run(logic [sv39ptb_pkg::VPN_W-1:0] va,
                         logic [sv39ptb_pkg::PPN_W-1:0] pa,
                         logic [sv39ptb_pkg::COUNT_W-1:0] n,
                         logic [sv39ptb_pkg::PERM_W-1:0] fl);
    send_request('{is_read: sv39ptb_pkg::OP_MAP, vpn: va, ppn: pa, count: n, perm: fl,
                   tsel: sv39ptb_pkg::TSEL_W'($urandom),
                   esel: sv39ptb_pkg::ENTRY_BITS'($urandom)});
  endtask

  task automatic read_entry(logic [sv39ptb_pkg::TSEL_W-1:0] t,
                            logic [sv39ptb_pkg::ENTRY_BITS-1:0] e);
    send_request('{is_read: sv39ptb_pkg::OP_READ, vpn: sv39ptb_pkg::VPN_W'($urandom),
                   ppn: sv39ptb_pkg::PPN_W'({$urandom, $urandom}),
                   count: sv39ptb_pkg::COUNT_W'($urandom),
                   perm: sv39ptb_pkg::PERM_W'($urandom), tsel: t, esel: e});
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    // a zero-count run leaves no result behind, give it time to retire
    repeat (40) @(posedge clk);
  endtask

  task automatic write_pool_base(logic [sv39ptb_pkg::PPN_W-1:0] b);
    cfg_valid <= 1'b1;
    cfg_data  <= b;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_base(b);
  endtask

  task automatic random_phase(int unsigned items);
    logic [sv39ptb_pkg::VPN_W-1:0] va;
    int unsigned pick;
    for (int unsigned k = 0; k < items; k++) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        read_entry(sv39ptb_pkg::TSEL_W'($urandom), sv39ptb_pkg::ENTRY_BITS'($urandom));
      end else begin
        // mostly stay inside a few regions so tables get reused
        va[8:0] = sv39ptb_pkg::ENTRY_BITS'($urandom);
        case ($urandom_range(3))
          0: va[17:9] = 9'd0;
          1: va[17:9] = 9'd1;
          2: va[17:9] = 9'h1ff;
          default: va[17:9] = 9'($urandom);
        endcase
        case ($urandom_range(4))
          0: va[26:18] = 9'd0;
          1: va[26:18] = 9'h1ff;
          2: va[26:18] = 9'd3;
          3: va[26:18] = 9'd0;
          default: va[26:18] = 9'($urandom);
        endcase
        map_run(va, sv39ptb_pkg::PPN_W'({$urandom, $urandom}),
                (pick < 30) ? sv39ptb_pkg::COUNT_W'($urandom) :
                              sv39ptb_pkg::COUNT_W'($urandom_range(1, 6)),
                sv39ptb_pkg::PERM_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_pool_base('0);

    // directed: extremes, wraps, saturation, zero count, exhaustion
    read_entry(4'd0, 9'd0);
    read_entry(4'hf, 9'h1ff);
    map_run('0, '0, 7'd1, 8'h00);
    map_run('1, '1, 7'd2, 8'hff);
    map_run(27'h200, 44'h123456789ab, 7'd0, 8'h55);
    map_run(27'h200, 44'h0fedcba9876, 7'd127, 8'haa);
    read_entry(4'd0, 9'd0);
    read_entry(4'd1, 9'd0);
    read_entry(4'd2, 9'h1ff);
    for (int k = 2; k < 10; k++)
      map_run(sv39ptb_pkg::VPN_W'(k) << 18, sv39ptb_pkg::PPN_W'(k), 7'd1, 8'h0e);
    read_entry(4'hf, 9'd0);
    map_run(27'h0000400, 44'h1, 7'd64, 8'h1f);
    drain_results();

    write_pool_base('1);
    send_idle_pct = 53; recv_stall_pct = 0;
    random_phase(70);
    drain_results();

    write_pool_base(sv39ptb_pkg::PPN_W'({$urandom, $urandom}));
    send_idle_pct = 0; recv_stall_pct = 53;
    random_phase(70);
    drain_results();

    write_pool_base('0);
    send_idle_pct = 27; recv_stall_pct = 27;
    random_phase(70);
    send_idle_pct = 0; recv_stall_pct = 0;
    random_phase(70);
    drain_results();
    repeat (60) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
